// ===== hw/rtl/quadratic_real_roots_defines.svh =====
// Assertion macros for the quadratic real roots block.
// Used by the top level only; needs nothing else.
`ifndef QUADRATIC_REAL_ROOTS_DEFINES_SVH
`define QUADRATIC_REAL_ROOTS_DEFINES_SVH

// Same-cycle implication, reset-qualified.
`define QRR_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset-qualified.
`define QRR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/qrr_pkg.sv =====
// Shared codes and types for the quadratic real roots block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qrr_pkg;

  localparam int unsigned ROOT_W = 32;

  typedef logic [1:0] status_t;
  localparam status_t ST_NONE    = 2'd0;
  localparam status_t ST_ONE     = 2'd1;
  localparam status_t ST_TWO     = 2'd2;
  localparam status_t ST_INVALID = 2'd3;

  // Discriminant class, decided by the front end
  typedef logic [1:0] class_t;
  localparam class_t CL_INVALID = 2'd0;
  localparam class_t CL_NEG     = 2'd1;
  localparam class_t CL_ZERO    = 2'd2;
  localparam class_t CL_POS     = 2'd3;

  localparam logic signed [ROOT_W-1:0] ROOT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ROOT_W-1:0] ROOT_MIN = 32'sh8000_0000;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

endpackage
`default_nettype wire

// ===== hw/rtl/qrr_front.sv =====
// Front end: accepts coefficient sets, forms the exact discriminant and classifies it.
// Depends on qrr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qrr_front #(
  parameter int COEF_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [COEF_WIDTH-1:0] in_coef_a,
  input  wire logic signed [COEF_WIDTH-1:0] in_coef_b,
  input  wire logic signed [COEF_WIDTH-1:0] in_coef_c,
  input  wire qrr_pkg::q_flags_t       q_flags,
  output logic                         push,
  output qrr_pkg::class_t              push_cls,
  output logic signed [COEF_WIDTH:0]   push_negb,
  output logic signed [COEF_WIDTH:0]   push_den,
  output logic [2*COEF_WIDTH:0]        push_rad
);
  import qrr_pkg::*;

  localparam int W   = COEF_WIDTH;
  localparam int PW  = 2 * W;
  localparam int DSW = 2 * W + 3;
  localparam int DW  = 2 * W + 1;

  logic                 fe;
  logic                 f1_valid_r, f2_valid_r;
  logic signed [PW-1:0] f1_bb_r, f1_ac_r, bb_nxt, ac_nxt;
  logic                 f1_azero_r;
  logic signed [W:0]    f1_negb_r, f1_den_r, negb_nxt, den_nxt;
  logic signed [DSW-1:0] disc_nxt;
  class_t               cls_nxt, f2_cls_r;
  logic signed [W:0]    f2_negb_r, f2_den_r;
  logic [DW-1:0]        f2_rad_r;

  // Hold everything while the last stage waits on a full queue
  assign fe       = !(f2_valid_r && q_flags.full);
  assign in_stall = !fe;

  assign bb_nxt   = in_coef_b * in_coef_b;
  assign ac_nxt   = in_coef_a * in_coef_c;
  assign negb_nxt = -$signed({in_coef_b[W-1], in_coef_b});
  assign den_nxt  = $signed({in_coef_a, 1'b0});

  assign disc_nxt = $signed({{3{f1_bb_r[PW-1]}}, f1_bb_r})
                  - $signed({f1_ac_r[PW-1], f1_ac_r, 2'b00});

  always_comb begin
    if (f1_azero_r) begin
      cls_nxt = CL_INVALID;
    end else if (disc_nxt[DSW-1]) begin
      cls_nxt = CL_NEG;
    end else if (disc_nxt == '0) begin
      cls_nxt = CL_ZERO;
    end else begin
      cls_nxt = CL_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else if (fe) begin
      f1_valid_r <= in_valid;
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      f1_bb_r    <= bb_nxt;
      f1_ac_r    <= ac_nxt;
      f1_azero_r <= (in_coef_a == '0);
      f1_negb_r  <= negb_nxt;
      f1_den_r   <= den_nxt;
      f2_cls_r   <= cls_nxt;
      f2_negb_r  <= f1_negb_r;
      f2_den_r   <= f1_den_r;
      f2_rad_r   <= disc_nxt[DW-1:0];
    end
  end

  assign push      = f2_valid_r && fe;
  assign push_cls  = f2_cls_r;
  assign push_negb = f2_negb_r;
  assign push_den  = f2_den_r;
  assign push_rad  = f2_rad_r;

endmodule
`default_nettype wire

// ===== hw/rtl/qrr_queue.sv =====
// Short transaction queue between the front end and the back end.
// Depends on qrr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qrr_queue #(
  parameter int DATA_W = 69
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      pop_data,
  output qrr_pkg::q_flags_t      flags
);
  import qrr_pkg::*;

  logic [DATA_W-1:0] mem_r [0:Q_DEPTH-1];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]     cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign pop_data    = mem_r[rd_ptr_r];
  assign flags.full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign flags.empty = (cnt_r == '0);

endmodule
`default_nettype wire

// ===== hw/rtl/qrr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, truncating toward zero.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none
module qrr_div #(
  parameter int NUM_W = 18,
  parameter int DEN_W = 17,
  parameter int FRAC  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [NUM_W-1:0]       num,
  input  wire logic signed [DEN_W-1:0]       den,
  output logic signed [NUM_W+FRAC:0]         quo
);
  localparam int QW = NUM_W + FRAC;

  logic [NUM_W-1:0] num_mag;
  logic [DEN_W-1:0] den_mag;
  logic [QW-1:0]    dvd_r [0:QW-1];
  logic [DEN_W:0]   rem_r [0:QW-1];
  logic [DEN_W-1:0] dsr_r [0:QW-1];
  logic [QW-1:0]    q_r   [0:QW];
  logic             neg_r [0:QW];
  logic [DEN_W:0]   rem_nxt [0:QW-1];
  logic [QW-1:0]    q_nxt   [0:QW-1];
  logic signed [QW:0] quo_r;

  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

  always_comb begin
    logic [DEN_W:0] sh;
    logic           ge;
    for (int i = 0; i < QW; i++) begin
      sh = {rem_r[i][DEN_W-1:0], dvd_r[i][QW-1-i]};
      ge = (sh >= {1'b0, dsr_r[i]});
      rem_nxt[i] = ge ? (sh - {1'b0, dsr_r[i]}) : sh;
      q_nxt[i]   = {q_r[i][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_r[0] <= {num_mag, {FRAC{1'b0}}};
      rem_r[0] <= '0;
      dsr_r[0] <= den_mag;
      q_r[0]   <= '0;
      neg_r[0] <= num[NUM_W-1] ^ den[DEN_W-1];
      for (int i = 0; i < QW; i++) begin
        if (i < QW - 1) begin
          dvd_r[i+1] <= dvd_r[i];
          rem_r[i+1] <= rem_nxt[i];
          dsr_r[i+1] <= dsr_r[i];
        end
        q_r[i+1]   <= q_nxt[i];
        neg_r[i+1] <= neg_r[i];
      end
      quo_r <= neg_r[QW] ? -$signed({1'b0, q_r[QW]}) : $signed({1'b0, q_r[QW]});
    end
  end

  assign quo = quo_r;

endmodule
`default_nettype wire

// ===== hw/rtl/qrr_back.sv =====
// Back end: square root pipeline, two dividers, saturation and the result register.
// Depends on qrr_pkg and qrr_div.
`timescale 1ns / 1ps
`default_nettype none
module qrr_back #(
  parameter int COEF_WIDTH     = 16,
  parameter int ROOT_FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire qrr_pkg::q_flags_t           q_flags,
  output logic                             pop,
  input  wire logic [4*COEF_WIDTH+4:0]     q_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output qrr_pkg::status_t                 out_root_status,
  output logic signed [qrr_pkg::ROOT_W-1:0] out_first_root,
  output logic signed [qrr_pkg::ROOT_W-1:0] out_second_root,
  output logic                             out_root_overflow
);
  import qrr_pkg::*;

  localparam int W   = COEF_WIDTH;
  localparam int F   = ROOT_FRAC_BITS;
  localparam int DW  = 2 * W + 1;
  localparam int SW  = W + 1;
  localparam int RW  = 2 * SW;
  localparam int QW  = W + 2 + F;
  localparam int DL  = QW + 2;
  localparam int EXT = (QW + 1 > 33) ? QW + 1 : 33;
  localparam logic signed [EXT-1:0] SAT_MAX = EXT'(ROOT_MAX);
  localparam logic signed [EXT-1:0] SAT_MIN = EXT'(ROOT_MIN);

  logic en;

  class_t            h_cls;
  logic signed [W:0] h_negb, h_den;
  logic [DW-1:0]     h_rad;

  logic              s_valid_r [0:SW];
  class_t            s_cls_r   [0:SW];
  logic signed [W:0] s_negb_r  [0:SW];
  logic signed [W:0] s_den_r   [0:SW];
  logic [RW-1:0]     s_rad_r   [0:SW-1];
  logic [SW+1:0]     s_rem_r   [0:SW-1];
  logic [SW-1:0]     s_root_r  [0:SW];
  logic [SW+1:0]     rem_nxt   [0:SW-1];
  logic [SW-1:0]     root_nxt  [0:SW-1];

  logic                n_valid_r;
  class_t              n_cls_r;
  logic signed [W+1:0] n_num1_r, n_num2_r;
  logic signed [W:0]   n_den_r;

  logic   d_valid_r [0:DL-1];
  class_t d_cls_r   [0:DL-1];

  logic signed [QW:0]     quo1, quo2;
  logic signed [EXT-1:0]  q1e, q2e;
  logic signed [ROOT_W-1:0] r1, r2;
  logic                   o1, o2;

  status_t                st_nxt;
  logic signed [ROOT_W-1:0] first_nxt, second_nxt;
  logic                   ovf_nxt;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic signed [ROOT_W-1:0] out_first_r, out_second_r;
  logic                   out_ovf_r;

  // Whole back end advances together whenever the result register can move
  assign en  = !out_valid_r || !out_stall;
  assign pop = en && !q_flags.empty;

  assign {h_cls, h_negb, h_den, h_rad} = q_data;

  // One root bit per stage
  always_comb begin
    logic [SW+1:0] sh, trial;
    logic          ge;
    for (int k = 0; k < SW; k++) begin
      sh    = {s_rem_r[k][SW-1:0], s_rad_r[k][RW-1-2*k -: 2]};
      trial = {s_root_r[k], 2'b01};
      ge    = (sh >= trial);
      rem_nxt[k]  = ge ? (sh - trial) : sh;
      root_nxt[k] = {s_root_r[k][SW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SW; k++) s_valid_r[k] <= 1'b0;
      n_valid_r <= 1'b0;
      for (int j = 0; j < DL; j++) d_valid_r[j] <= 1'b0;
    end else if (en) begin
      s_valid_r[0] <= !q_flags.empty;
      for (int k = 0; k < SW; k++) s_valid_r[k+1] <= s_valid_r[k];
      n_valid_r    <= s_valid_r[SW];
      d_valid_r[0] <= n_valid_r;
      for (int j = 1; j < DL; j++) d_valid_r[j] <= d_valid_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_cls_r[0]  <= h_cls;
      s_negb_r[0] <= h_negb;
      s_den_r[0]  <= h_den;
      s_rad_r[0]  <= {1'b0, h_rad};
      s_rem_r[0]  <= '0;
      s_root_r[0] <= '0;
      for (int k = 0; k < SW; k++) begin
        s_cls_r[k+1]  <= s_cls_r[k];
        s_negb_r[k+1] <= s_negb_r[k];
        s_den_r[k+1]  <= s_den_r[k];
        s_root_r[k+1] <= root_nxt[k];
        if (k < SW - 1) begin
          s_rad_r[k+1] <= s_rad_r[k];
          s_rem_r[k+1] <= rem_nxt[k];
        end
      end
      n_cls_r  <= s_cls_r[SW];
      n_den_r  <= s_den_r[SW];
      n_num1_r <= $signed({s_negb_r[SW][W], s_negb_r[SW]}) + $signed({1'b0, s_root_r[SW]});
      n_num2_r <= $signed({s_negb_r[SW][W], s_negb_r[SW]}) - $signed({1'b0, s_root_r[SW]});
      d_cls_r[0] <= n_cls_r;
      for (int j = 1; j < DL; j++) d_cls_r[j] <= d_cls_r[j-1];
    end
  end

  qrr_div #(.NUM_W(W + 2), .DEN_W(W + 1), .FRAC(F)) u_div_plus (
    .clk (clk),
    .en  (en),
    .num (n_num1_r),
    .den (n_den_r),
    .quo (quo1)
  );

  qrr_div #(.NUM_W(W + 2), .DEN_W(W + 1), .FRAC(F)) u_div_minus (
    .clk (clk),
    .en  (en),
    .num (n_num2_r),
    .den (n_den_r),
    .quo (quo2)
  );

  // Saturate to the signed result width
  assign q1e = EXT'(quo1);
  assign q2e = EXT'(quo2);
  assign o1  = (q1e > SAT_MAX) || (q1e < SAT_MIN);
  assign o2  = (q2e > SAT_MAX) || (q2e < SAT_MIN);
  assign r1  = (q1e > SAT_MAX) ? ROOT_MAX : (q1e < SAT_MIN) ? ROOT_MIN : q1e[ROOT_W-1:0];
  assign r2  = (q2e > SAT_MAX) ? ROOT_MAX : (q2e < SAT_MIN) ? ROOT_MIN : q2e[ROOT_W-1:0];

  always_comb begin
    st_nxt     = ST_NONE;
    first_nxt  = '0;
    second_nxt = '0;
    ovf_nxt    = 1'b0;
    case (d_cls_r[DL-1])
      CL_INVALID: st_nxt = ST_INVALID;
      CL_NEG:     st_nxt = ST_NONE;
      CL_ZERO: begin
        st_nxt    = ST_ONE;
        first_nxt = r1;
        ovf_nxt   = o1;
      end
      CL_POS: begin
        first_nxt = r1;
        if (r1 == r2) begin
          st_nxt  = ST_ONE;
          ovf_nxt = o1;
        end else begin
          st_nxt     = ST_TWO;
          second_nxt = r2;
          ovf_nxt    = o1 || o2;
        end
      end
      default: st_nxt = ST_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid_r[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_status_r <= st_nxt;
      out_first_r  <= first_nxt;
      out_second_r <= second_nxt;
      out_ovf_r    <= ovf_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_root_status   = out_status_r;
  assign out_first_root    = out_first_r;
  assign out_second_root   = out_second_r;
  assign out_root_overflow = out_ovf_r;

endmodule
`default_nettype wire

// ===== hw/rtl/quadratic_real_roots.sv =====
// Top level of the quadratic real roots solver: front end, queue, back end, checks.
// Depends on qrr_pkg, qrr_front, qrr_queue, qrr_back and the defines header.
//
//   Channel  Ports                                   Direction  Moves
//   in       in_valid, in_stall, in_coef_a/b/c       into block one coefficient set
//   out      out_valid, out_stall, out_root_*, ...   out        one status and root pair
//
// One transaction enters per cycle and one result leaves per cycle in steady flow.
// Without stalls the latency is set by the root pipeline (one bit a stage) and by
// the two dividers (one quotient bit a stage), which dominate the path end to end.
// Reset (rst_n low, synchronous) empties every stage and the queue; no clearing pass.
// An output stall freezes the back end; the queue then fills and stalls the front end.
`timescale 1ns / 1ps
`default_nettype none
`include "quadratic_real_roots_defines.svh"
module quadratic_real_roots #(
  parameter int COEF_WIDTH     = 16,
  parameter int ROOT_FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COEF_WIDTH-1:0]  in_coef_a,
  input  wire logic signed [COEF_WIDTH-1:0]  in_coef_b,
  input  wire logic signed [COEF_WIDTH-1:0]  in_coef_c,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output qrr_pkg::status_t                   out_root_status,
  output logic signed [qrr_pkg::ROOT_W-1:0]  out_first_root,
  output logic signed [qrr_pkg::ROOT_W-1:0]  out_second_root,
  output logic                               out_root_overflow
);
  import qrr_pkg::*;

  // class, -b, 2a and the discriminant magnitude
  localparam int ENTRY_W = 4 * COEF_WIDTH + 5;

  q_flags_t                  q_flags;
  logic                      push, pop;
  class_t                    push_cls;
  logic signed [COEF_WIDTH:0] push_negb, push_den;
  logic [2*COEF_WIDTH:0]     push_rad;
  logic [ENTRY_W-1:0]        push_data, pop_data;

  // Front end: register products, form and classify the discriminant
  qrr_front #(.COEF_WIDTH(COEF_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_coef_a (in_coef_a),
    .in_coef_b (in_coef_b),
    .in_coef_c (in_coef_c),
    .q_flags   (q_flags),
    .push      (push),
    .push_cls  (push_cls),
    .push_negb (push_negb),
    .push_den  (push_den),
    .push_rad  (push_rad)
  );

  assign push_data = {push_cls, push_negb, push_den, push_rad};

  // Decouple the two halves so each can stall on its own
  qrr_queue #(.DATA_W(ENTRY_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .flags     (q_flags)
  );

  // Back end: square root, divide, saturate, hold the result
  qrr_back #(.COEF_WIDTH(COEF_WIDTH), .ROOT_FRAC_BITS(ROOT_FRAC_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_flags           (q_flags),
    .pop               (pop),
    .q_data            (pop_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_root_status   (out_root_status),
    .out_first_root    (out_first_root),
    .out_second_root   (out_second_root),
    .out_root_overflow (out_root_overflow)
  );

  // The input side only stalls behind a full queue
  `QRR_ASSERT_NOW(a_stall_needs_full, clk, rst_n, in_stall, q_flags.full, "input stalled without full queue")
  // Never pop an empty queue nor push a full one
  `QRR_ASSERT_NOW(a_queue_safe, clk, rst_n, pop || push, !(pop && q_flags.empty) && !(push && q_flags.full), "queue overrun or underrun")
  // Second root is only reported for two distinct roots
  `QRR_ASSERT_NOW(a_second_zero, clk, rst_n, out_valid && (out_root_status != ST_TWO), out_second_root == '0, "second root set without two roots")
  // Overflow only when a reported root sits at a saturation limit
  `QRR_ASSERT_NOW(a_ovf_sat, clk, rst_n, out_valid && out_root_overflow, (out_first_root == ROOT_MAX) || (out_first_root == ROOT_MIN) || (out_second_root == ROOT_MAX) || (out_second_root == ROOT_MIN), "overflow without saturated root")

endmodule
`default_nettype wire
